/* rtl/mrp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrp_pkg: shared types and constants of the Modbus RTU request parser
// Function codes, frame limits, the job record passed from the front to the
// back, the result record and the CRC-16/MODBUS byte update.
// ----------------------------------------------------------------------------
package mrp_pkg;

  localparam int MaxFrameBytes = 256;
  localparam int PosW          = $clog2(MaxFrameBytes + 1);
  // Wide enough for byte positions and 7 + byte count + 1.
  localparam int CmpW          = (PosW > 10) ? PosW + 1 : 11;

  localparam int JobDepth = 4;

  localparam logic [7:0] FnReadFirst  = 8'd1;
  localparam logic [7:0] FnReadLast   = 8'd4;
  localparam logic [7:0] FnWriteCoil  = 8'd5;
  localparam logic [7:0] FnWriteReg   = 8'd6;
  localparam logic [7:0] FnWriteCoils = 8'd15;
  localparam logic [7:0] FnWriteRegs  = 8'd16;

  localparam logic [7:0] CoilOnByte = 8'hFF;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusMalformed = 2'd1;
  localparam logic [1:0] StatusCrcError  = 2'd2;

  localparam logic KindCell    = 1'b0;
  localparam logic KindSummary = 1'b1;

  // One job per input byte that produces results.
  typedef struct packed {
    logic [7:0]  slave;
    logic [7:0]  func;
    logic [15:0] addr;
    logic [15:0] qty;
    logic [3:0]  cell_cnt;   // cells to emit, 0..8
    logic        coil_bits;  // value[7:0] holds one coil per bit
    logic [15:0] base_idx;
    logic [15:0] value;
    logic        summary;
    logic [1:0]  status;
    logic [15:0] cell_total;
  } mrp_job_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  slave;
    logic [7:0]  func;
    logic [15:0] addr;
    logic [15:0] qty;
    logic [15:0] idx;
    logic [15:0] value;
    logic [1:0]  status;
    logic        last;
  } mrp_result_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* rtl/mrp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrp_front: byte parser
// Tracks the frame position, header fields, CRC and errors, and turns each
// accepted byte into at most one job for the back end.
// ----------------------------------------------------------------------------
module mrp_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       data_byte_i,
  input  logic             frame_last_i,
  input  logic             cfg_we_i,
  input  logic             cfg_data_i,
  output logic             job_valid_o,
  output mrp_pkg::mrp_job_t job_o
);

  logic [mrp_pkg::PosW-1:0] pos_q, pos_d;
  logic [7:0]  slave_q, slave_d, func_q, func_d, bc_q, bc_d, pend_q, pend_d;
  logic [7:0]  crc_low_q, crc_low_d;
  logic [15:0] addr_q, addr_d, qty_q, qty_d, cells_q, cells_d, crc_q, crc_d;
  logic [1:0]  err_q, err_d;
  logic        crc_en_q;

  logic                     fixed_c, multi_c, fixed_n, multi_n, in_range, body;
  logic [mrp_pkg::CmpW-1:0] p_x, crc_pos, off, len_x, crc_pos_n;
  logic [15:0]              base, w;
  logic [16:0]              rem, need;
  logic [17:0]              need_end;
  logic [1:0]               status;

  always_comb begin
    pos_d     = pos_q;
    slave_d   = slave_q;
    func_d    = func_q;
    addr_d    = addr_q;
    qty_d     = qty_q;
    bc_d      = bc_q;
    pend_d    = pend_q;
    cells_d   = cells_q;
    crc_d     = crc_q;
    crc_low_d = crc_low_q;
    err_d     = err_q;
    job_o     = '0;

    fixed_c  = (func_q >= mrp_pkg::FnReadFirst) && (func_q <= mrp_pkg::FnWriteReg);
    multi_c  = (func_q == mrp_pkg::FnWriteCoils) || (func_q == mrp_pkg::FnWriteRegs);
    p_x      = mrp_pkg::CmpW'(pos_q);
    crc_pos  = multi_c ? (mrp_pkg::CmpW'(7) + mrp_pkg::CmpW'(bc_q)) : mrp_pkg::CmpW'(6);
    in_range = p_x < mrp_pkg::CmpW'(mrp_pkg::MaxFrameBytes);
    body     = multi_c ? (p_x < crc_pos) : (fixed_c ? (p_x < mrp_pkg::CmpW'(6)) : 1'b1);
    off      = p_x - mrp_pkg::CmpW'(7);
    base     = 16'({off, 3'b000});
    rem      = {1'b0, qty_q} - {1'b0, base};
    w        = {pend_q, data_byte_i};

    if (in_range) begin
      if (body) begin
        crc_d = mrp_pkg::crc16_byte(crc_q, data_byte_i);
      end else if (p_x == crc_pos) begin
        crc_low_d = data_byte_i;
      end else if (p_x == crc_pos + mrp_pkg::CmpW'(1)) begin
        if ({data_byte_i, crc_low_q} != crc_q) begin
          err_d[1] = 1'b1;
        end
      end

      case (p_x)
        mrp_pkg::CmpW'(0): begin
          slave_d = data_byte_i;
        end
        mrp_pkg::CmpW'(1): begin
          func_d = data_byte_i;
          if (data_byte_i == mrp_pkg::FnWriteCoil || data_byte_i == mrp_pkg::FnWriteReg) begin
            qty_d = 16'd1;
          end
        end
        mrp_pkg::CmpW'(2): begin
          addr_d[15:8] = data_byte_i;
        end
        mrp_pkg::CmpW'(3): begin
          addr_d[7:0] = data_byte_i;
        end
        mrp_pkg::CmpW'(4): begin
          pend_d = data_byte_i;
          if (func_q == mrp_pkg::FnWriteCoil) begin
            job_o.cell_cnt = 4'd1;
            job_o.value    = {15'd0, data_byte_i == mrp_pkg::CoilOnByte};
            cells_d        = 16'd1;
          end
        end
        mrp_pkg::CmpW'(5): begin
          if ((func_q >= mrp_pkg::FnReadFirst && func_q <= mrp_pkg::FnReadLast) || multi_c) begin
            qty_d = w;
          end else if (func_q == mrp_pkg::FnWriteReg) begin
            job_o.cell_cnt = 4'd1;
            job_o.value    = w;
            cells_d        = 16'd1;
          end
        end
        mrp_pkg::CmpW'(6): begin
          if (multi_c) begin
            bc_d = data_byte_i;
          end
        end
        default: begin
          if (multi_c && (p_x < crc_pos)) begin
            if (func_q == mrp_pkg::FnWriteCoils) begin
              if (!rem[16] && (rem != 17'd0)) begin
                job_o.cell_cnt  = (rem >= 17'd8) ? 4'd8 : rem[3:0];
                job_o.coil_bits = 1'b1;
                job_o.base_idx  = base;
                job_o.value     = {8'h00, data_byte_i};
                cells_d         = base + 16'(job_o.cell_cnt);
              end
            end else if (!off[0]) begin
              pend_d = data_byte_i;
            end else if (16'(off[mrp_pkg::CmpW-1:1]) < qty_q) begin
              job_o.cell_cnt = 4'd1;
              job_o.base_idx = 16'(off[mrp_pkg::CmpW-1:1]);
              job_o.value    = w;
              cells_d        = 16'(off[mrp_pkg::CmpW-1:1]) + 16'd1;
            end
          end
        end
      endcase
      pos_d = pos_q + mrp_pkg::PosW'(1);
    end

    // Byte count check: taken at byte 6, with the quantity already final.
    fixed_n = (func_d >= mrp_pkg::FnReadFirst) && (func_d <= mrp_pkg::FnWriteReg);
    multi_n = (func_d == mrp_pkg::FnWriteCoils) || (func_d == mrp_pkg::FnWriteRegs);
    need    = (func_d == mrp_pkg::FnWriteCoils) ? ((17'(qty_d) + 17'd7) >> 3) : {qty_d, 1'b0};
    if (in_range && (p_x == mrp_pkg::CmpW'(6)) && multi_c && (need > 17'(data_byte_i))) begin
      err_d[0] = 1'b1;
    end

    // Frame summary, built from the state as this byte leaves it.
    len_x     = mrp_pkg::CmpW'(pos_d);
    crc_pos_n = multi_n ? (mrp_pkg::CmpW'(7) + mrp_pkg::CmpW'(bc_d)) : mrp_pkg::CmpW'(6);
    need_end  = 18'd7 + 18'(need);
    status    = mrp_pkg::StatusOk;
    if (fixed_n) begin
      if (len_x < mrp_pkg::CmpW'(6)) begin
        status = mrp_pkg::StatusMalformed;
      end
    end else if (multi_n) begin
      if ((len_x < mrp_pkg::CmpW'(7)) || err_d[0] || (18'(len_x) < need_end)) begin
        status = mrp_pkg::StatusMalformed;
      end
    end else begin
      status = mrp_pkg::StatusMalformed;
    end
    if ((status == mrp_pkg::StatusOk) && crc_en_q) begin
      if (len_x < crc_pos_n + mrp_pkg::CmpW'(2)) begin
        status = mrp_pkg::StatusMalformed;
      end else if (err_d[1]) begin
        status = mrp_pkg::StatusCrcError;
      end
    end

    job_o.slave      = slave_d;
    job_o.func       = func_d;
    job_o.addr       = addr_d;
    job_o.qty        = qty_d;
    job_o.summary    = frame_last_i;
    job_o.status     = status;
    job_o.cell_total = cells_d;
    job_valid_o      = (job_o.cell_cnt != 4'd0) || frame_last_i;

    // Drop all frame state after the last byte.
    if (frame_last_i) begin
      pos_d     = '0;
      slave_d   = '0;
      func_d    = '0;
      addr_d    = '0;
      qty_d     = '0;
      bc_d      = '0;
      pend_d    = '0;
      cells_d   = '0;
      crc_d     = mrp_pkg::CrcInit;
      crc_low_d = '0;
      err_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      slave_q   <= '0;
      func_q    <= '0;
      addr_q    <= '0;
      qty_q     <= '0;
      bc_q      <= '0;
      pend_q    <= '0;
      cells_q   <= '0;
      crc_q     <= mrp_pkg::CrcInit;
      crc_low_q <= '0;
      err_q     <= '0;
      crc_en_q  <= 1'b1;
    end else begin
      if (accept_i) begin
        pos_q     <= pos_d;
        slave_q   <= slave_d;
        func_q    <= func_d;
        addr_q    <= addr_d;
        qty_q     <= qty_d;
        bc_q      <= bc_d;
        pend_q    <= pend_d;
        cells_q   <= cells_d;
        crc_q     <= crc_d;
        crc_low_q <= crc_low_d;
        err_q     <= err_d;
      end
      if (cfg_we_i) begin
        crc_en_q <= cfg_data_i;
      end
    end
  end

endmodule

/* rtl/mrp_job_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrp_job_fifo: job queue between parser and result generator
// Small register queue; lets the parser run ahead of the result side.
// ----------------------------------------------------------------------------
module mrp_job_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  mrp_pkg::mrp_job_t wr_data_i,
  output logic              full_o,
  input  logic              rd_i,
  output logic              valid_o,
  output mrp_pkg::mrp_job_t rd_data_o
);

  localparam int PtrW = $clog2(mrp_pkg::JobDepth);
  localparam int CntW = $clog2(mrp_pkg::JobDepth + 1);

  mrp_pkg::mrp_job_t mem_q [mrp_pkg::JobDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(mrp_pkg::JobDepth));
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(mrp_pkg::JobDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(mrp_pkg::JobDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* rtl/mrp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrp_back: result generator
// Expands the head job into its cells, then any frame summary, one result per
// cycle when not stalled; each is held in an output register until popped.
// ----------------------------------------------------------------------------
module mrp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_valid_i,
  input  mrp_pkg::mrp_job_t    job_i,
  output logic                 job_pop_o,
  output logic                 empty_o,
  input  logic                 pop_i,
  output mrp_pkg::mrp_result_t res_o
);

  logic [3:0]           step_q;
  logic                 out_valid_q;
  mrp_pkg::mrp_result_t out_q, res_d;
  logic                 adv, gen, is_cell;

  assign adv     = !out_valid_q || pop_i;
  assign gen     = adv && job_valid_i;
  assign is_cell = step_q < job_i.cell_cnt;

  always_comb begin
    res_d.kind   = is_cell ? mrp_pkg::KindCell : mrp_pkg::KindSummary;
    res_d.slave  = job_i.slave;
    res_d.func   = job_i.func;
    res_d.addr   = job_i.addr;
    res_d.qty    = job_i.qty;
    res_d.idx    = is_cell ? (job_i.base_idx + 16'(step_q)) : job_i.cell_total;
    res_d.value  = '0;
    res_d.status = mrp_pkg::StatusOk;
    res_d.last   = 1'b1;
    if (is_cell) begin
      res_d.value = job_i.coil_bits ? {15'd0, job_i.value[step_q[2:0]]} : job_i.value;
      res_d.last  = (step_q == job_i.cell_cnt - 4'd1) && !job_i.summary;
    end else begin
      res_d.status = job_i.status;
    end
  end

  assign job_pop_o = gen && res_d.last;
  assign empty_o   = !out_valid_q;
  assign res_o     = out_q;

  always_ff @(posedge clk_i) begin
    if (gen) begin
      out_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_q <= job_valid_i;
      end
      if (gen) begin
        step_q <= res_d.last ? 4'd0 : step_q + 4'd1;
      end
    end
  end

endmodule

/* rtl/modbus_rtu_request_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_request_parser: Modbus RTU request frame parser
// Parses request frames byte by byte, emits one result per written coil or
// register and a status summary at each frame end.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                Beat
// input     in         push / full              data_byte_i, frame_last_i
// result    out        empty / pop              result_kind_o .. last_in_run_o
// config    in         cfg_valid_i / cfg_ready_o  cfg_data_i (crc_check_enable)
//
// The parser front takes one byte per cycle; each byte yields at most one job
// into a four-entry queue. The back end drains one result per cycle while its
// output is popped, so a byte yields 0 to 9 results (a coil data byte with the
// frame end gives eight cells plus a summary). Reset clears the frame state,
// loads the CRC with 0xFFFF and turns the CRC check on. full stalls input only
// when the job queue is full; a held result never blocks parsing until then.
module modbus_rtu_request_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_last_i,
  // results
  output logic        empty,
  input  logic        pop,
  output logic        result_kind_o,
  output logic [7:0]  slave_address_o,
  output logic [7:0]  function_number_o,
  output logic [15:0] start_address_o,
  output logic [15:0] quantity_o,
  output logic [15:0] value_index_o,
  output logic [15:0] cell_value_o,
  output logic [1:0]  frame_status_o,
  output logic        last_in_run_o,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);

  mrp_pkg::mrp_job_t    front_job, head_job;
  mrp_pkg::mrp_result_t res;
  logic                 front_job_valid, q_full, q_valid, q_pop, in_beat;

  // Accept a byte whenever the queue has room for the job it may make.
  assign full        = q_full;
  assign in_beat     = push && !q_full;
  assign cfg_ready_o = 1'b1;

  mrp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_beat),
    .data_byte_i  (data_byte_i),
    .frame_last_i (frame_last_i),
    .cfg_we_i     (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .job_valid_o  (front_job_valid),
    .job_o        (front_job)
  );

  // Bytes that produce no result leave nothing in the queue.
  mrp_job_fifo u_job_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (in_beat && front_job_valid),
    .wr_data_i (front_job),
    .full_o    (q_full),
    .rd_i      (q_pop),
    .valid_o   (q_valid),
    .rd_data_o (head_job)
  );

  mrp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (head_job),
    .job_pop_o   (q_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res)
  );

  assign result_kind_o     = res.kind;
  assign slave_address_o   = res.slave;
  assign function_number_o = res.func;
  assign start_address_o   = res.addr;
  assign quantity_o        = res.qty;
  assign value_index_o     = res.idx;
  assign cell_value_o      = res.value;
  assign frame_status_o    = res.status;
  assign last_in_run_o     = res.last;

endmodule
